>>> design/gae_pkg.sv
// ----------------------------------------------------------------------------
// gae_pkg
// Shared constants, types and arithmetic helpers for the GAE normalizer.
// ----------------------------------------------------------------------------
package gae_pkg;

  localparam int unsigned MAX_STEPS = 4096;
  localparam int unsigned AW        = $clog2(MAX_STEPS);
  localparam int unsigned CW        = AW + 1;

  localparam logic [15:0] DISCOUNT_RST    = 16'd64881;
  localparam logic [15:0] TRACE_DECAY_RST = 16'd62259;

  localparam logic [1:0] CFG_DISCOUNT    = 2'd0;
  localparam logic [1:0] CFG_TRACE_DECAY = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // q16.16 times q0.16 product, rounded half up back to q16.16
  function automatic logic signed [32:0] mul_round(input logic signed [48:0] p);
    logic signed [48:0] s;
    s = p + 49'sd32768;
    return s[48:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -36'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

>>> design/gae_if.sv
// ----------------------------------------------------------------------------
// gae channel interfaces
// Valid/ready channels for step items and result items.
// ----------------------------------------------------------------------------
interface gae_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] reward;
  logic [31:0] value_estimate;
  logic        done_req;
  logic        last_step;
  logic [11:0] index;

  modport source (output valid, func, reward, value_estimate, done_req, last_step, index,
                  input ready);
  modport sink   (input valid, func, reward, value_estimate, done_req, last_step, index,
                  output ready);
endinterface

interface gae_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] advantage;
  logic [31:0] return_value;
  logic [1:0]  status;

  modport source (output valid, advantage, return_value, status, input ready);
  modport sink   (input valid, advantage, return_value, status, output ready);
endinterface

>>> design/gae_advantage_return_normalizer_core.sv
// ----------------------------------------------------------------------------
// gae_advantage_return_normalizer_core
// GAE advantage and return over a stored trajectory, then normalization.
// ----------------------------------------------------------------------------
// Usage: step items arrive on in_i, results leave on out_o (valid/ready).
// A load (func 0) writes one step into the step memory; the
// load that carries last_step launches the pass over the trajectory, during
// which in_i.ready stays low. For n steps that pass runs a backward walk
// (one memory read/multiply/add per step), the mean and variance streams,
// the mean and variance divides, a square root, and one divide per step for
// normalization while the square root is nonzero; all divides share the
// serial divider.
// A read (func 1) gives one result, via the result memory and S_RD for a
// stored step, directly for a status-only answer. A result waits in the
// output register until out_o takes it; no new item is accepted meanwhile.
// Reset clears the step count and the results-ready flag and restores the
// discount and trace decay registers; memories hold their contents, and
// only entries written in the current trajectory are ever used.
// ----------------------------------------------------------------------------
module gae_advantage_return_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  gae_in_if.sink      in_i,
  gae_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned AW  = gae_pkg::AW;
  localparam int unsigned CW  = gae_pkg::CW;
  localparam int unsigned SW  = 32 + CW;
  localparam int unsigned SQW = 48 + AW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_GL, S_BRD, S_BMUL, S_BADD, S_SUM, S_MEAN, S_MEANW,
    S_VAR, S_VARS, S_VARW, S_SQRT, S_NRD, S_NDAT, S_NDIV
  } state_e;

  state_e state_q;

  // step memory {reward, value, done} and result memory {advantage, return}
  logic [64:0] step_mem [gae_pkg::MAX_STEPS];
  logic [63:0] res_mem  [gae_pkg::MAX_STEPS];
  logic [64:0] a_rdata_q;
  logic [63:0] b_rdata_q;
  logic        a_we;
  logic [AW-1:0] a_waddr;
  logic        b_we;
  logic [AW-1:0] b_waddr;
  logic [63:0] b_wdata;
  logic [AW-1:0] b_raddr;

  logic [15:0] disc_q, td_q, gl_q;
  logic [CW-1:0] cnt_q, cnt_base, cnt_new, t_q, iss_q;
  logic        rdy_q;

  logic        ovalid_q;
  logic [31:0] oadv_q, oret_q;
  logic [1:0]  ostat_q;

  logic signed [31:0] adv_q, ret_q, nextv_q, r_q, v_q;
  logic        dn_q, first_q;
  logic signed [48:0] pv_q, pa_q, pr_q;
  logic signed [31:0] adv_n, ret_n;
  logic        restart;

  logic        p1_q, p2_q, p3_q;
  logic signed [SW-1:0] sum_q;
  logic signed [31:0] mean_q;
  logic [31:0] m_q, hh_q, hl_q, ll_q;
  logic [SQW-1:0] sq_q;
  logic [63:0] term;
  logic signed [32:0] dvar;

  logic [63:0] sq_x_q;
  logic [35:0] sq_rem_q, rem_sh, trial;
  logic [31:0] sq_root_q;
  logic [4:0]  sq_cnt_q;

  logic        nneg_q;
  logic [31:0] nret_q;
  logic signed [32:0] dn_d;
  logic [31:0] dmag;
  logic [31:0] nout;

  logic        sneg;
  logic [SW-1:0] smag;
  logic [SW-1:0] sdividend;

  gae_pkg::div_req_t div_req;
  logic        div_done;
  logic [63:0] div_q;

  logic        in_acc;
  logic        last_norm;

  gae_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_q)
  );

  assign in_i.ready         = (state_q == S_IDLE) && !ovalid_q;
  assign in_acc             = in_i.valid && in_i.ready;
  assign out_o.valid        = ovalid_q;
  assign out_o.advantage    = oadv_q;
  assign out_o.return_value = oret_q;
  assign out_o.status       = ostat_q;

  // a load after a finished pass starts a new trajectory
  assign cnt_base = rdy_q ? '0 : cnt_q;
  assign a_we     = in_acc && (in_i.func == gae_pkg::FUNC_LOAD) &&
                    (cnt_base < CW'(gae_pkg::MAX_STEPS));
  assign a_waddr  = cnt_base[AW-1:0];
  assign cnt_new  = a_we ? cnt_base + CW'(1) : cnt_base;

  // backward step
  assign restart = first_q || dn_q;
  always_comb begin
    logic signed [35:0] a_sum;
    logic signed [35:0] r_sum;
    if (restart) begin
      a_sum = 36'(r_q) - 36'(v_q);
      r_sum = 36'(r_q);
    end else begin
      a_sum = 36'(r_q) + 36'(gae_pkg::mul_round(pv_q)) - 36'(v_q)
            + 36'(gae_pkg::mul_round(pa_q));
      r_sum = 36'(r_q) + 36'(gae_pkg::mul_round(pr_q));
    end
    adv_n = gae_pkg::sat32(a_sum);
    ret_n = gae_pkg::sat32(r_sum);
  end

  // mean and variance helpers
  assign sneg      = sum_q[SW-1];
  assign smag      = sneg ? SW'(-sum_q) : SW'(sum_q);
  assign sdividend = sneg ? smag + SW'(cnt_q) - SW'(1) : smag;
  assign dvar      = 33'($signed(b_rdata_q[63:32])) - 33'(mean_q);
  assign term      = ({hh_q, 32'b0} + {15'b0, hl_q, 17'b0} + {32'b0, ll_q}) >> 16;

  // square root step
  assign rem_sh = {sq_rem_q[33:0], sq_x_q[63:62]};
  assign trial  = {2'b00, sq_root_q, 2'b01};

  // normalization
  assign dn_d = 33'($signed(b_rdata_q[63:32])) - 33'(mean_q);
  assign dmag = dn_d[32] ? 32'(-dn_d) : 32'(dn_d);
  always_comb begin
    if (nneg_q) begin
      nout = (div_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_q[31:0]);
    end else begin
      nout = (div_q > 64'h7fff_ffff) ? 32'h7fff_ffff : div_q[31:0];
    end
  end
  assign last_norm = (iss_q == cnt_q - CW'(1));

  always_comb begin
    div_req = '0;
    case (state_q)
      S_MEAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(sdividend);
        div_req.divisor  = 32'(cnt_q);
      end
      S_VARS: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(sq_q);
        div_req.divisor  = 32'(cnt_q);
      end
      S_NDAT: begin
        div_req.start    = (sq_root_q != '0);
        div_req.dividend = 64'({dmag, 16'b0}) + 64'(sq_root_q[31:1]);
        div_req.divisor  = sq_root_q;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    b_we    = 1'b0;
    b_waddr = iss_q[AW-1:0];
    b_wdata = {oadv_q, nret_q};
    b_raddr = iss_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        b_raddr = in_i.index;
      end
      S_BADD: begin
        b_we    = 1'b1;
        b_waddr = t_q[AW-1:0];
        b_wdata = {adv_n, ret_n};
      end
      S_NDAT: begin
        b_we    = (sq_root_q == '0);
        b_wdata = {32'b0, b_rdata_q[31:0]};
      end
      S_NDIV: begin
        b_we    = div_done;
        b_wdata = {nout, nret_q};
      end
      default: begin
        b_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      step_mem[a_waddr] <= {in_i.reward, in_i.value_estimate, in_i.done_req};
    end
    a_rdata_q <= step_mem[t_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      res_mem[b_waddr] <= b_wdata;
    end
    b_rdata_q <= res_mem[b_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      disc_q    <= gae_pkg::DISCOUNT_RST;
      td_q      <= gae_pkg::TRACE_DECAY_RST;
      gl_q      <= '0;
      cnt_q     <= '0;
      rdy_q     <= 1'b0;
      t_q       <= '0;
      iss_q     <= '0;
      ovalid_q  <= 1'b0;
      oadv_q    <= '0;
      oret_q    <= '0;
      ostat_q   <= gae_pkg::ST_OK;
      adv_q     <= '0;
      ret_q     <= '0;
      nextv_q   <= '0;
      r_q       <= '0;
      v_q       <= '0;
      dn_q      <= 1'b0;
      first_q   <= 1'b0;
      pv_q      <= '0;
      pa_q      <= '0;
      pr_q      <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p3_q      <= 1'b0;
      sum_q     <= '0;
      mean_q    <= '0;
      m_q       <= '0;
      hh_q      <= '0;
      hl_q      <= '0;
      ll_q      <= '0;
      sq_q      <= '0;
      sq_x_q    <= '0;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= '0;
      nneg_q    <= 1'b0;
      nret_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == gae_pkg::CFG_DISCOUNT) begin
        disc_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == gae_pkg::CFG_TRACE_DECAY) begin
        td_q <= cfg_wdata_i;
      end
      // only a waiting beat is retired; a new one is set only while empty
      if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc && in_i.func == gae_pkg::FUNC_LOAD) begin
            cnt_q <= cnt_new;
            rdy_q <= 1'b0;
            if (in_i.last_step && cnt_new != '0) begin
              state_q <= S_GL;
            end
          end else if (in_acc) begin
            if (!rdy_q) begin
              ovalid_q <= 1'b1;
              oadv_q   <= '0;
              oret_q   <= '0;
              ostat_q  <= gae_pkg::ST_NONE;
            end else if (CW'(in_i.index) >= cnt_q) begin
              ovalid_q <= 1'b1;
              oadv_q   <= '0;
              oret_q   <= '0;
              ostat_q  <= gae_pkg::ST_RANGE;
            end else begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          ovalid_q <= 1'b1;
          oadv_q   <= b_rdata_q[63:32];
          oret_q   <= b_rdata_q[31:0];
          ostat_q  <= gae_pkg::ST_OK;
          state_q  <= S_IDLE;
        end
        S_GL: begin
          gl_q    <= 16'((32'(disc_q) * 32'(td_q) + 32'd32768) >> 16);
          t_q     <= cnt_q - CW'(1);
          first_q <= 1'b1;
          state_q <= S_BRD;
        end
        S_BRD: begin
          state_q <= S_BMUL;
        end
        S_BMUL: begin
          pv_q    <= nextv_q * $signed({1'b0, disc_q});
          pa_q    <= adv_q * $signed({1'b0, gl_q});
          pr_q    <= ret_q * $signed({1'b0, disc_q});
          r_q     <= a_rdata_q[64:33];
          v_q     <= a_rdata_q[32:1];
          dn_q    <= a_rdata_q[0];
          state_q <= S_BADD;
        end
        S_BADD: begin
          adv_q   <= adv_n;
          ret_q   <= ret_n;
          nextv_q <= v_q;
          first_q <= 1'b0;
          if (t_q == '0) begin
            iss_q   <= '0;
            p1_q    <= 1'b0;
            sum_q   <= '0;
            state_q <= S_SUM;
          end else begin
            t_q     <= t_q - CW'(1);
            state_q <= S_BRD;
          end
        end
        S_SUM: begin
          p1_q <= (iss_q != cnt_q);
          if (iss_q != cnt_q) begin
            iss_q <= iss_q + CW'(1);
          end
          if (p1_q) begin
            sum_q <= sum_q + SW'($signed(b_rdata_q[63:32]));
          end
          if (iss_q == cnt_q && !p1_q) begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: begin
          state_q <= S_MEANW;
        end
        S_MEANW: begin
          if (div_done) begin
            mean_q  <= sneg ? 32'(-div_q[31:0]) : div_q[31:0];
            iss_q   <= '0;
            p1_q    <= 1'b0;
            p2_q    <= 1'b0;
            p3_q    <= 1'b0;
            sq_q    <= '0;
            state_q <= S_VAR;
          end
        end
        S_VAR: begin
          p1_q <= (iss_q != cnt_q);
          p2_q <= p1_q;
          p3_q <= p2_q;
          if (iss_q != cnt_q) begin
            iss_q <= iss_q + CW'(1);
          end
          m_q  <= dvar[32] ? 32'(-dvar) : 32'(dvar);
          hh_q <= m_q[31:16] * m_q[31:16];
          hl_q <= m_q[31:16] * m_q[15:0];
          ll_q <= m_q[15:0] * m_q[15:0];
          if (p3_q) begin
            sq_q <= sq_q + SQW'(term);
          end
          if (iss_q == cnt_q && !p1_q && !p2_q && !p3_q) begin
            state_q <= S_VARS;
          end
        end
        S_VARS: begin
          state_q <= S_VARW;
        end
        S_VARW: begin
          if (div_done) begin
            sq_x_q    <= {div_q[47:0], 16'b0};
            sq_rem_q  <= '0;
            sq_root_q <= '0;
            sq_cnt_q  <= '0;
            state_q   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_x_q   <= {sq_x_q[61:0], 2'b00};
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (rem_sh >= trial) begin
            sq_rem_q  <= rem_sh - trial;
            sq_root_q <= {sq_root_q[30:0], 1'b1};
          end else begin
            sq_rem_q  <= rem_sh;
            sq_root_q <= {sq_root_q[30:0], 1'b0};
          end
          if (sq_cnt_q == 5'd31) begin
            iss_q   <= '0;
            state_q <= S_NRD;
          end
        end
        S_NRD: begin
          state_q <= S_NDAT;
        end
        S_NDAT: begin
          nneg_q <= dn_d[32];
          nret_q <= b_rdata_q[31:0];
          if (sq_root_q != '0) begin
            state_q <= S_NDIV;
          end else if (last_norm) begin
            rdy_q   <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            iss_q   <= iss_q + CW'(1);
            state_q <= S_NRD;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            if (last_norm) begin
              rdy_q   <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              iss_q   <= iss_q + CW'(1);
              state_q <= S_NRD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // steps are only stored while no pass is running
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_we |-> state_q == S_IDLE)
    else $error("step memory written outside idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(gae_pkg::MAX_STEPS))
    else $error("step count beyond capacity");

  // results are never flagged ready while a pass is in progress
  a_rdy_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_RD) |-> !rdy_q)
    else $error("results ready during pass");

  // a divide only finishes where the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_MEANW || state_q == S_VARW || state_q == S_NDIV))
    else $error("divider finished unexpectedly");

  // a waiting beat is not replaced before it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_o.ready) |=> ovalid_q && $stable(oadv_q) && $stable(ostat_q))
    else $error("result beat lost");
`endif

endmodule

>>> design/gae_div.sv
// ----------------------------------------------------------------------------
// gae_div
// Restoring unsigned divider for a 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gae_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gae_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic [63:0]        quot_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [32:0] rem_q;
  logic [63:0] quo_q;
  logic [31:0] dvs_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        fits;

  assign rem_sh  = {rem_q[31:0], quo_q[63]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sub : rem_sh;
        quo_q <= {quo_q[62:0], fits};
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> sim/tb_gae_advantage_return_normalizer_core.sv
// ----------------------------------------------------------------------------
// tb_gae_advantage_return_normalizer_core
// Self-checking bench for the GAE advantage/return normalizer: directed rows
// and random trajectories go in, every read beat is checked against a local
// fixed-point model of the backward pass and normalization.
// ----------------------------------------------------------------------------
module tb_gae_advantage_return_normalizer_core;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic       FUNC_READ = 1'b1;

  typedef struct {
    logic        func;
    logic [31:0] reward;
    logic [31:0] value_est;
    logic        done;
    logic        last;
    logic [11:0] index;
    bit          known;
    logic [31:0] adv;
    logic [31:0] ret;
    logic [1:0]  status;
  } row_t;

  typedef struct {
    logic [31:0] adv;
    logic [31:0] ret;
    logic [1:0]  status;
  } readback_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  gae_in_if  in_ch ();
  gae_out_if out_ch ();

  gae_advantage_return_normalizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // model state
  logic [15:0] gamma_q;
  logic [15:0] lambda_q;
  int          rew_mem [gae_pkg::MAX_STEPS];
  int          val_mem [gae_pkg::MAX_STEPS];
  bit          done_mem[gae_pkg::MAX_STEPS];
  int          adv_mem [gae_pkg::MAX_STEPS];
  int          ret_mem [gae_pkg::MAX_STEPS];
  int          traj_len;
  bit          traj_ready;

  readback_t   pending_reads[$];
  int          mismatches;
  int          items_sent;
  bit          calm;
  int          rx_hold;

  function automatic longint floor_q(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint scale_frac(longint a, longint g);
    return floor_q(a * g + 32768, 65536);
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic run_gae_pass();
    longint          gl, adv, ret, sum, mean, d, r, v, outv;
    longint unsigned sq, var_q, sd, m, q;
    int              n;
    n = traj_len;
    gl = (longint'(gamma_q) * longint'(lambda_q) + 32768) >>> 16;
    adv = 0;
    ret = 0;
    sum = 0;
    sq = 0;
    for (int i = n - 1; i >= 0; i--) begin
      r = rew_mem[i];
      v = val_mem[i];
      if (i == n - 1 || done_mem[i]) begin
        adv = clamp32(r - v);
        ret = r;
      end else begin
        adv = clamp32(r + scale_frac(val_mem[i+1], gamma_q) - v + scale_frac(adv, gl));
        ret = clamp32(r + scale_frac(ret, gamma_q));
      end
      adv_mem[i] = int'(adv);
      ret_mem[i] = int'(ret);
    end
    for (int i = 0; i < n; i++) sum += adv_mem[i];
    mean = floor_q(sum, n);
    for (int i = 0; i < n; i++) begin
      d = longint'(adv_mem[i]) - mean;
      m = (d < 0) ? -d : d;
      sq += (m * m) >> 16;
    end
    var_q = sq / n;
    sd = int_sqrt(var_q << 16);
    for (int i = 0; i < n; i++) begin
      d = longint'(adv_mem[i]) - mean;
      if (sd == 0) begin
        outv = 0;
      end else begin
        m = ((d < 0) ? -d : d) << 16;
        q = (m + sd / 2) / sd;
        if (d < 0) outv = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        else outv = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      end
      adv_mem[i] = int'(outv);
    end
  endtask

  // one accepted input beat; returns 1 with the readback when a result is due
  task automatic model_item(input row_t it, output bit has_res, output readback_t rb);
    has_res = 1'b0;
    rb = '{32'd0, 32'd0, gae_pkg::ST_OK};
    if (it.func == gae_pkg::FUNC_LOAD) begin
      if (traj_ready) begin
        traj_ready = 1'b0;
        traj_len = 0;
      end
      if (traj_len < gae_pkg::MAX_STEPS) begin
        rew_mem[traj_len] = it.reward;
        val_mem[traj_len] = it.value_est;
        done_mem[traj_len] = it.done;
        traj_len++;
      end
      if (it.last && traj_len > 0) begin
        run_gae_pass();
        traj_ready = 1'b1;
      end
    end else begin
      has_res = 1'b1;
      if (!traj_ready) rb.status = gae_pkg::ST_NONE;
      else if (int'(it.index) >= traj_len) rb.status = gae_pkg::ST_RANGE;
      else rb = '{adv_mem[it.index], ret_mem[it.index], gae_pkg::ST_OK};
    end
  endtask

  task automatic send(input row_t it);
    bit        has_res;
    readback_t rb;
    if (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= it.func;
    in_ch.reward         <= it.reward;
    in_ch.value_estimate <= it.value_est;
    in_ch.done_req       <= it.done;
    in_ch.last_step      <= it.last;
    in_ch.index          <= it.index;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    model_item(it, has_res, rb);
    if (has_res) begin
      if (it.known && (rb.adv !== it.adv || rb.ret !== it.ret || rb.status !== it.status)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("model disagrees with table row: adv %h ret %h st %0d", rb.adv, rb.ret,
                   rb.status);
      end
      pending_reads.insert(pending_reads.size(), rb);
    end
    items_sent++;
  endtask

  function automatic row_t load_row(logic [31:0] r, logic [31:0] v, logic dn, logic lst);
    return '{gae_pkg::FUNC_LOAD, r, v, dn, lst, 12'($urandom), 1'b0, 32'd0, 32'd0,
             gae_pkg::ST_OK};
  endfunction

  function automatic row_t read_row(logic [11:0] idx);
    return '{FUNC_READ, $urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
             idx, 1'b0, 32'd0, 32'd0, gae_pkg::ST_OK};
  endfunction

  // read whose answer is typed in
  function automatic row_t known_read(logic [11:0] idx, logic [31:0] adv, logic [31:0] ret,
                                      logic [1:0] st);
    return '{FUNC_READ, 32'd0, 32'd0, 1'b0, 1'b0, idx, 1'b1, adv, ret, st};
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == gae_pkg::CFG_DISCOUNT) gamma_q = data;
    else if (idx == gae_pkg::CFG_TRACE_DECAY) lambda_q = data;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_trajectory();
    int len;
    len = ($urandom_range(19) == 0) ? $urandom_range(32, 128) : $urandom_range(1, 12);
    for (int s = 0; s < len; s++) begin
      if ($urandom_range(9) == 0) send(read_row(12'($urandom_range(0, 15))));
      send(load_row(rand_q16(), rand_q16(), $urandom_range(4) == 0, s == len - 1));
    end
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(4) == 0) send(read_row(12'($urandom)));
      else send(read_row(12'($urandom_range(0, len + 1))));
    end
  endtask

  // result side: random stalls, long hold-offs on request
  initial begin
    readback_t e;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: status %0d", out_ch.status);
        end else begin
          e = pending_reads.pop_front();
          if (out_ch.advantage !== e.adv || out_ch.return_value !== e.ret ||
              out_ch.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp adv %h ret %h st %0d, got adv %h ret %h st %0d",
                       e.adv, e.ret, e.status, out_ch.advantage, out_ch.return_value,
                       out_ch.status);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    #(64'd80_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [15:0] g_set[5];
    logic [15:0] l_set[5];
    gamma_q = gae_pkg::DISCOUNT_RST;
    lambda_q = gae_pkg::TRACE_DECAY_RST;
    traj_len = 0;
    traj_ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    calm = 1'b0;
    rx_hold = 0;
    in_ch.valid <= 1'b0;
    in_ch.func <= gae_pkg::FUNC_LOAD;
    in_ch.reward <= '0;
    in_ch.value_estimate <= '0;
    in_ch.done_req <= 1'b0;
    in_ch.last_step <= 1'b0;
    in_ch.index <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    rows.insert(rows.size(), known_read(12'd0, 32'd0, 32'd0, gae_pkg::ST_NONE));
    rows.insert(rows.size(), known_read(12'hfff, 32'd0, 32'd0, gae_pkg::ST_NONE));
    rows.insert(rows.size(), load_row(32'h7fffffff, 32'h80000000, 1'b0, 1'b0));
    rows.insert(rows.size(), load_row(32'h80000000, 32'h7fffffff, 1'b1, 1'b0));
    rows.insert(rows.size(), load_row(32'h0, 32'h0, 1'b0, 1'b1));
    rows.insert(rows.size(), read_row(12'd0));
    rows.insert(rows.size(), read_row(12'd1));
    rows.insert(rows.size(), read_row(12'd2));
    rows.insert(rows.size(), known_read(12'd3, 32'd0, 32'd0, gae_pkg::ST_RANGE));
    rows.insert(rows.size(), known_read(12'hfff, 32'd0, 32'd0, gae_pkg::ST_RANGE));
    // single step: zero variance, return is the reward
    rows.insert(rows.size(), load_row(32'h0001_0000, 32'h0, 1'b0, 1'b1));
    rows.insert(rows.size(), known_read(12'd0, 32'd0, 32'h0001_0000, gae_pkg::ST_OK));
    rows.insert(rows.size(), load_row(32'h0005_0000, 32'h0005_0000, 1'b1, 1'b0));
    // read mid-trajectory: previous results are gone
    rows.insert(rows.size(), known_read(12'd0, 32'd0, 32'd0, gae_pkg::ST_NONE));
    rows.insert(rows.size(), load_row(32'h0005_0000, 32'h0005_0000, 1'b1, 1'b1));
    rows.insert(rows.size(), read_row(12'd0));
    rows.insert(rows.size(), read_row(12'd1));
    rows.insert(rows.size(), load_row(32'hffff_0000, 32'h0002_8000, 1'b0, 1'b0));
    rows.insert(rows.size(), load_row(32'h0003_0001, 32'hfffe_ffff, 1'b0, 1'b0));
    rows.insert(rows.size(), load_row(32'h0000_0001, 32'h0000_0000, 1'b0, 1'b1));
    rows.insert(rows.size(), read_row(12'd0));
    rows.insert(rows.size(), read_row(12'd1));
    rows.insert(rows.size(), read_row(12'd2));
    foreach (rows[k]) send(rows[k]);
    settle();

    g_set = '{16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0};
    l_set = '{16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0};
    g_set[4] = 16'($urandom);
    l_set[4] = 16'($urandom);
    write_reg(CFG_SPARE, 16'hffff);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_reg(gae_pkg::CFG_DISCOUNT, g_set[ph]);
        write_reg(gae_pkg::CFG_TRACE_DECAY, l_set[ph]);
      end else begin
        write_reg(gae_pkg::CFG_DISCOUNT, gae_pkg::DISCOUNT_RST);
        write_reg(gae_pkg::CFG_TRACE_DECAY, gae_pkg::TRACE_DECAY_RST);
      end
      calm = (ph == 2);
      for (int t = 0; t < 8; t++) random_trajectory();
      // hold the result side off while reads pile up behind it
      if (ph == 1) begin
        rx_hold = 400;
        repeat (6) send(read_row(12'($urandom_range(0, 3))));
      end
      settle();
    end
    calm = 1'b0;

    write_reg(gae_pkg::CFG_DISCOUNT, 16'($urandom));
    write_reg(gae_pkg::CFG_TRACE_DECAY, 16'($urandom));
    while (items_sent < 1600) random_trajectory();
    settle();

    // full store: the extra load is dropped, its last_step still starts the pass
    for (int s = 0; s < gae_pkg::MAX_STEPS; s++)
      send(load_row(rand_q16(), rand_q16(), $urandom_range(7) == 0, 1'b0));
    send(load_row(32'h7fffffff, 32'h7fffffff, 1'b0, 1'b1));
    send(read_row(12'd0));
    send(read_row(12'hfff));
    send(read_row(12'($urandom)));

    settle();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
